// File: rtl/core/sia_pkg.sv
// ----------------------------------------------------------------------------
// Slot index allocator package
// Shared sizes, result codes, opcodes and memory command structures.
// ----------------------------------------------------------------------------
`default_nettype none

package sia_pkg;

    // Pool size and field widths.
    localparam int SLOTS    = 1024;
    localparam int SLOT_W   = 10;
    localparam int INDEX_W  = 11;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 2;

    // The allocated map is kept as rows of MAP_W bits.
    localparam int MAP_W    = 32;
    localparam int MAP_ROWS = SLOTS / MAP_W;
    localparam int ROW_W    = $clog2(MAP_ROWS);
    localparam int BIT_W    = $clog2(MAP_W);

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC   = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FREED   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // Commands to the free stack.
    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_pos;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_pos;
        logic [SLOT_W-1:0] wr_slot;
        logic              pop_en;
        logic [SLOT_W-1:0] pop_pos;
    } stk_cmd_t;

    // Commands to the allocated map.
    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [MAP_W-1:0] wr_data;
    } map_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/sia_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/sia_free_stack.sv
// ----------------------------------------------------------------------------
// Free index stack
// Stack storage in RAM; entries below the low-water mark were never written and
// read back as their position, the value they hold at reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_free_stack (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sia_pkg::stk_cmd_t             cmd,
    output logic      [sia_pkg::SLOT_W-1:0]    rd_slot
);

    logic [sia_pkg::COUNT_W-1:0] low_reg;
    logic [sia_pkg::COUNT_W-1:0] low_next;
    logic [sia_pkg::SLOT_W-1:0]  rd_pos_reg;
    logic [sia_pkg::SLOT_W-1:0]  ram_rdata;

    // The stack never shrank below low_reg, so no entry under it was written.
    always_comb
    begin
        low_next = low_reg;
        if (cmd.pop_en && ({1'b0, cmd.pop_pos} < low_reg))
        begin
            low_next = {1'b0, cmd.pop_pos};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg <= sia_pkg::COUNT_W'(sia_pkg::SLOTS);
        end
        else
        begin
            low_reg <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_pos_reg <= cmd.rd_pos;
        end
    end

    sia_ram #(
        .WIDTH (sia_pkg::SLOT_W),
        .DEPTH (sia_pkg::SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_pos),
        .wdata (cmd.wr_slot),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_pos),
        .rdata (ram_rdata)
    );

    assign rd_slot = ({1'b0, rd_pos_reg} >= low_reg) ? ram_rdata : rd_pos_reg;

endmodule

`default_nettype wire

// File: rtl/core/sia_alloc_map.sv
// ----------------------------------------------------------------------------
// Allocated slot map
// One bit per slot, stored as RAM rows; a row never written reads as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sia_alloc_map (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sia_pkg::map_cmd_t           cmd,
    output logic      [sia_pkg::MAP_W-1:0]   rd_data
);

    logic [sia_pkg::MAP_ROWS-1:0] row_valid_reg;
    logic                         rd_valid_reg;
    logic [sia_pkg::MAP_W-1:0]    ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_en)
            begin
                row_valid_reg[cmd.wr_row] <= 1'b1;
            end
            if (cmd.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[cmd.rd_row];
            end
        end
    end

    sia_ram #(
        .WIDTH (sia_pkg::MAP_W),
        .DEPTH (sia_pkg::MAP_ROWS)
    ) u_map_ram (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (cmd.wr_row),
        .wdata (cmd.wr_data),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_row),
        .rdata (ram_rdata)
    );

    assign rd_data = rd_valid_reg ? ram_rdata : '0;

endmodule

`default_nettype wire

// File: rtl/core/slot_index_allocator.sv
// ----------------------------------------------------------------------------
// Slot index allocator
// Hands out slot indices from a LIFO free stack and guards frees with an
// allocated-bit map; both live in synchronous RAMs.
// ----------------------------------------------------------------------------
// A free or an allocate on an empty pool passes through IDLE and LOOK and writes
// its result from LOOK; a successful allocate goes on to MARK and writes it from
// there. A new request is taken only in IDLE, once the last result is written;
// an allocate needs MARK because the stack read precedes the dependent
// read-modify-write of the map row.
// Reset: ready right after reset, with no clearing pass; the stack holds
// indices 0 to SLOTS-1 with SLOTS-1 on top and the map reads all zero.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_index_allocator (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            opcode,
    input  wire logic [sia_pkg::INDEX_W-1:0]     slot_index,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [sia_pkg::STATUS_W-1:0]    status,
    output logic      [sia_pkg::SLOT_W-1:0]      granted_slot,
    output logic      [sia_pkg::COUNT_W-1:0]     free_count
);

    // IDLE takes a request and issues both memory reads. LOOK sees the stack
    // top and the map row of the freed slot. MARK updates the map row of the
    // slot that an allocate popped.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_MARK
    } state_t;

    state_t                       state_reg;
    state_t                       state_next;
    logic [sia_pkg::COUNT_W-1:0]  depth_reg;
    logic [sia_pkg::COUNT_W-1:0]  depth_next;
    sia_pkg::opcode_t             op_reg;
    logic [sia_pkg::INDEX_W-1:0]  idx_reg;
    logic [sia_pkg::SLOT_W-1:0]   slot_reg;
    logic [sia_pkg::SLOT_W-1:0]   slot_next;

    logic                         out_valid_reg;
    sia_pkg::status_t             status_reg;
    logic [sia_pkg::SLOT_W-1:0]   grant_reg;
    logic [sia_pkg::COUNT_W-1:0]  count_reg;

    logic                         load;
    sia_pkg::status_t             status_next;
    logic [sia_pkg::SLOT_W-1:0]   grant_next;
    logic                         out_free;
    logic                         accept;
    logic                         free_ok;

    sia_pkg::stk_cmd_t            stk_cmd;
    sia_pkg::map_cmd_t            map_cmd;
    logic [sia_pkg::SLOT_W-1:0]   stk_slot;
    logic [sia_pkg::MAP_W-1:0]    map_row;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // A result may be written when the output register is empty or is being
    // taken in this cycle.
    assign out_free = !out_valid_reg || out_ready;

    // A free is honored only for an in-range slot whose map bit is set, and
    // only while the stack has room.
    assign free_ok = (idx_reg < sia_pkg::INDEX_W'(sia_pkg::SLOTS))
                     && map_row[idx_reg[sia_pkg::BIT_W-1:0]]
                     && (depth_reg < sia_pkg::COUNT_W'(sia_pkg::SLOTS));

    always_comb
    begin
        stk_cmd     = '0;
        map_cmd     = '0;
        load        = 1'b0;
        status_next = sia_pkg::ST_IGNORED;
        grant_next  = '0;
        depth_next  = depth_reg;
        slot_next   = slot_reg;
        state_next  = state_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // Read the stack top and the map row of the given slot;
                    // the request type decides later which one counts.
                    stk_cmd.rd_en  = 1'b1;
                    stk_cmd.rd_pos = sia_pkg::SLOT_W'(depth_reg - 1'b1);
                    map_cmd.rd_en  = 1'b1;
                    map_cmd.rd_row = slot_index[sia_pkg::SLOT_W-1:sia_pkg::BIT_W];
                    state_next     = S_LOOK;
                end
            end

            S_LOOK:
            begin
                if (op_reg == sia_pkg::OP_ALLOC)
                begin
                    if (depth_reg == '0)
                    begin
                        if (out_free)
                        begin
                            load        = 1'b1;
                            status_next = sia_pkg::ST_EMPTY;
                            state_next  = S_IDLE;
                        end
                    end
                    else
                    begin
                        slot_next      = stk_slot;
                        map_cmd.rd_en  = 1'b1;
                        map_cmd.rd_row = stk_slot[sia_pkg::SLOT_W-1:sia_pkg::BIT_W];
                        state_next     = S_MARK;
                    end
                end
                else if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (free_ok)
                    begin
                        status_next     = sia_pkg::ST_FREED;
                        map_cmd.wr_en   = 1'b1;
                        map_cmd.wr_row  = idx_reg[sia_pkg::SLOT_W-1:sia_pkg::BIT_W];
                        map_cmd.wr_data = map_row
                            & ~(sia_pkg::MAP_W'(1) << idx_reg[sia_pkg::BIT_W-1:0]);
                        stk_cmd.wr_en   = 1'b1;
                        stk_cmd.wr_pos  = depth_reg[sia_pkg::SLOT_W-1:0];
                        stk_cmd.wr_slot = idx_reg[sia_pkg::SLOT_W-1:0];
                        depth_next      = depth_reg + 1'b1;
                    end
                    else
                    begin
                        status_next = sia_pkg::ST_IGNORED;
                    end
                end
            end

            S_MARK:
            begin
                if (out_free)
                begin
                    load            = 1'b1;
                    status_next     = sia_pkg::ST_ALLOC;
                    grant_next      = slot_reg;
                    map_cmd.wr_en   = 1'b1;
                    map_cmd.wr_row  = slot_reg[sia_pkg::SLOT_W-1:sia_pkg::BIT_W];
                    map_cmd.wr_data = map_row
                        | (sia_pkg::MAP_W'(1) << slot_reg[sia_pkg::BIT_W-1:0]);
                    stk_cmd.pop_en  = 1'b1;
                    stk_cmd.pop_pos = sia_pkg::SLOT_W'(depth_reg - 1'b1);
                    depth_next      = depth_reg - 1'b1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= sia_pkg::COUNT_W'(sia_pkg::SLOTS);
            op_reg        <= sia_pkg::OP_ALLOC;
            idx_reg       <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= sia_pkg::ST_ALLOC;
            grant_reg     <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            slot_reg  <= slot_next;
            if (accept)
            begin
                op_reg  <= sia_pkg::opcode_t'(opcode);
                idx_reg <= slot_index;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
                status_reg    <= status_next;
                grant_reg     <= grant_next;
                count_reg     <= depth_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    sia_free_stack u_free_stack (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (stk_cmd),
        .rd_slot (stk_slot)
    );

    sia_alloc_map u_alloc_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (map_cmd),
        .rd_data (map_row)
    );

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign granted_slot = grant_reg;
    assign free_count   = count_reg;

    // The stack depth never exceeds the pool size.
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= sia_pkg::COUNT_W'(sia_pkg::SLOTS))
        else $error("stack depth above pool size");

    // A successful free pushes exactly one index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (status_next == sia_pkg::ST_FREED))
        |=> (depth_reg == $past(depth_reg) + 1'b1))
        else $error("free did not grow the stack by one");

    // A successful allocate pops exactly one index.
    assert property (@(posedge clk) disable iff (!rst_n)
        (load && (status_next == sia_pkg::ST_ALLOC))
        |=> (depth_reg == $past(depth_reg) - 1'b1))
        else $error("allocate did not shrink the stack by one");

    // A pending result always reports the current number of free slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg == depth_reg))
        else $error("reported free count differs from stack depth");

    // Only an allocate result carries a nonzero slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg != sia_pkg::ST_ALLOC)) |-> (grant_reg == '0))
        else $error("slot reported without an allocate");

endmodule

`default_nettype wire
